FILE: hw/rtl/e2dcm_pkg.sv
// shared types, constants and helper functions for the euler angle to dcm unit
// no dependencies; imported by e2dcm_sincos, e2dcm_matmul and the top level
`default_nettype none

package e2dcm_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int WORK_BITS  = 30;
   localparam int REM_BITS   = ANGLE_BITS - 2;
   localparam int ORDER_BITS = 3;

   // pi in q40, split in two halves for the angle scaling multiply
   localparam logic [41:0] PI_Q40   = 42'h3243F6A8886;
   localparam int          PI_SPLIT = 21;
   localparam logic [20:0] PI_HI    = PI_Q40[41:21];
   localparam logic [20:0] PI_LO    = PI_Q40[20:0];
   localparam int          X_SHIFT  = 9 + ANGLE_BITS;

   localparam int X_BITS     = 31;
   localparam int TERM_BITS  = 32;
   localparam int ACC_BITS   = 34;
   localparam int TERM_STEPS = 8;

   // depth from angle capture to registered sine and cosine
   localparam int SC_LAT = 3 + 2 * TERM_STEPS + 1;

   localparam int OUT_BITS = FRAC_BITS + 2;
   localparam int FINAL_SHIFT = 2 * WORK_BITS - FRAC_BITS;

   typedef logic signed [31:0]   trig_type;
   typedef logic signed [32:0]   elem_type;
   typedef logic signed [65:0]   prod_type;
   typedef logic signed [67:0]   sum_type;
   typedef elem_type mat_type [3][3];
   typedef sum_type  sum_mat_type [3][3];

   localparam logic [ORDER_BITS-1:0] ORDER_XYZ = 3'd0;
   localparam logic [ORDER_BITS-1:0] ORDER_XZY = 3'd1;
   localparam logic [ORDER_BITS-1:0] ORDER_YXZ = 3'd2;
   localparam logic [ORDER_BITS-1:0] ORDER_YZX = 3'd3;
   localparam logic [ORDER_BITS-1:0] ORDER_ZXY = 3'd4;
   localparam logic [ORDER_BITS-1:0] ORDER_ZYX = 3'd5;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                  valid;
      logic [ORDER_BITS-1:0] order;
   } tag_type;

   typedef struct packed {
      logic valid;
      logic err;
   } ctl_type;

   // taylor divisors n*(n+1) for step k of each series
   function automatic int sin_div(input int k);
      sin_div = (2 * k + 2) * (2 * k + 3);
   endfunction

   function automatic int cos_div(input int k);
      cos_div = (2 * k + 1) * (2 * k + 2);
   endfunction

   function automatic logic order_bad(input logic [ORDER_BITS-1:0] order);
      order_bad = (order != ORDER_XYZ) && (order != ORDER_XZY) && (order != ORDER_YXZ) &&
                  (order != ORDER_YZX) && (order != ORDER_ZXY) && (order != ORDER_ZYX);
   endfunction

   // axis of rotation number pos (0 first) for an order code
   function automatic logic [1:0] axis_of(input logic [ORDER_BITS-1:0] order, input int pos);
      logic [1:0] a0;
      logic [1:0] a1;
      logic [1:0] a2;
      a0 = AXIS_X;
      a1 = AXIS_Y;
      a2 = AXIS_Z;
      case (order)
         ORDER_XYZ: begin a0 = AXIS_X; a1 = AXIS_Y; a2 = AXIS_Z; end
         ORDER_XZY: begin a0 = AXIS_X; a1 = AXIS_Z; a2 = AXIS_Y; end
         ORDER_YXZ: begin a0 = AXIS_Y; a1 = AXIS_X; a2 = AXIS_Z; end
         ORDER_YZX: begin a0 = AXIS_Y; a1 = AXIS_Z; a2 = AXIS_X; end
         ORDER_ZXY: begin a0 = AXIS_Z; a1 = AXIS_X; a2 = AXIS_Y; end
         ORDER_ZYX: begin a0 = AXIS_Z; a1 = AXIS_Y; a2 = AXIS_X; end
         default:   begin a0 = AXIS_X; a1 = AXIS_Y; a2 = AXIS_Z; end
      endcase
      if (pos == 0) axis_of = a0;
      else if (pos == 1) axis_of = a1;
      else axis_of = a2;
   endfunction

   // passive single-axis rotation in q30
   function automatic mat_type axis_mat(input logic [1:0] axis, input trig_type s,
                                        input trig_type c);
      mat_type    m;
      logic [1:0] j;
      logic [1:0] k;
      j = (axis == AXIS_X) ? AXIS_Y : ((axis == AXIS_Y) ? AXIS_Z : AXIS_X);
      k = (axis == AXIS_X) ? AXIS_Z : ((axis == AXIS_Y) ? AXIS_X : AXIS_Y);
      for (int r = 0; r < 3; r++) begin
         for (int q = 0; q < 3; q++) begin
            if (r == int'(axis) && q == int'(axis)) m[r][q] = elem_type'(64'sd1 <<< WORK_BITS);
            else if (r == q) m[r][q] = elem_type'(c);
            else if (r == int'(j) && q == int'(k)) m[r][q] = elem_type'(s);
            else if (r == int'(k) && q == int'(j)) m[r][q] = -elem_type'(s);
            else m[r][q] = '0;
         end
      end
      axis_mat = m;
   endfunction

   // round to nearest, ties away from zero, constant shift
   function automatic sum_type round_shift(input sum_type v, input int sh);
      sum_type half;
      sum_type mag;
      half = sum_type'(1) <<< (sh - 1);
      mag  = (v < 0) ? -v : v;
      mag  = (mag + half) >>> sh;
      round_shift = (v < 0) ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/euler_angles_to_dcm_unit.sv
// top level: euler angles to direction cosine matrix, streaming in and out
// depends on e2dcm_pkg, e2dcm_sincos and e2dcm_matmul
`default_nettype none

// Converts three binary angles (65536 per turn) and a rotation order into the
// nine elements of the passive direction cosine matrix R3*R2*R1, signed with
// 16 fraction bits, rounded and saturated to +-1.0. Orders 0..5 are XYZ, XZY,
// YXZ, YZX, ZXY, ZYX; codes 6 and 7 return a zero matrix with order_error set.
// One request is accepted every cycle while the skid stage is empty. A
// result passes the sine/cosine pipeline (20 stages, two per taylor term),
// the order decode stage, the two matrix products (two stages each), their
// rounding stages and the output register. Backpressure freezes the whole
// pipeline only once a result waits in the output register and a second one
// has been parked in the skid stage, so no request is lost or repeated.
module euler_angles_to_dcm_unit
   import e2dcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request: first_angle[15:0], second_angle[31:16], third_angle[47:32]
   input  wire logic [47:0]  req_tdata,
   // request: axis_order[2:0]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // result: m00[17:0], m01, m02, m10, m11, m12, m20, m21, m22[161:144], zero pad
   output      logic [167:0] rsp_tdata,
   // result: order_error[0]
   output      logic         rsp_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready
);

   localparam int NELEM = 9;

   logic    pipe_en;
   tag_type tag_ff [SC_LAT];
   trig_type sin_w [3];
   trig_type cos_w [3];

   // rotation matrices, order decode stage
   mat_type r1_ff, r2_ff, r3_ff;
   ctl_type ctl_b_ff;

   // first product and its rounding
   sum_mat_type t_sum;
   ctl_type     ctl_m1_ff [2];
   mat_type     tmp_ff;
   ctl_type     ctl_r_ff;
   mat_type     r1d_ff [3];

   // second product and final rounding
   sum_mat_type f_sum;
   ctl_type     ctl_m2_ff [2];
   logic [OUT_BITS-1:0] fin_ff [NELEM];
   ctl_type     ctl_f_ff;

   // output register and skid stage
   logic [OUT_BITS*NELEM-1:0] out_ff, skid_ff, fin_flat;
   logic out_err_ff, skid_err_ff;
   logic out_v_ff, skid_v_ff;
   logic take_out;

   // pipeline moves whenever the skid stage is free
   assign pipe_en    = !skid_v_ff;
   assign req_tready = pipe_en;
   assign take_out   = out_v_ff && rsp_tready;

   for (genvar a = 0; a < 3; a++) begin : g_angle
      e2dcm_sincos u_sincos (
         .clock   (clock),
         .en      (pipe_en),
         .angle   (req_tdata[a*ANGLE_BITS +: ANGLE_BITS]),
         .sin_out (sin_w[a]),
         .cos_out (cos_w[a])
      );
   end

   // valid and order travel beside the sine/cosine pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SC_LAT; i++) tag_ff[i] <= '0;
      end else if (pipe_en) begin
         tag_ff[0] <= {req_tvalid, req_tuser};
         for (int i = 1; i < SC_LAT; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   // build the three single-axis matrices for the requested order
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         r1_ff <= axis_mat(axis_of(tag_ff[SC_LAT-1].order, 0), sin_w[0], cos_w[0]);
         r2_ff <= axis_mat(axis_of(tag_ff[SC_LAT-1].order, 1), sin_w[1], cos_w[1]);
         r3_ff <= axis_mat(axis_of(tag_ff[SC_LAT-1].order, 2), sin_w[2], cos_w[2]);
      end
   end

   e2dcm_matmul u_mm_first (
      .clock    (clock),
      .en       (pipe_en),
      .lhs      (r3_ff),
      .rhs      (r2_ff),
      .prod_sum (t_sum)
   );

   // q60 back to q30
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               tmp_ff[r][c] <= elem_type'(round_shift(t_sum[r][c], WORK_BITS));
         r1d_ff[0] <= r1_ff;
         r1d_ff[1] <= r1d_ff[0];
         r1d_ff[2] <= r1d_ff[1];
      end
   end

   e2dcm_matmul u_mm_second (
      .clock    (clock),
      .en       (pipe_en),
      .lhs      (tmp_ff),
      .rhs      (r1d_ff[2]),
      .prod_sum (f_sum)
   );

   // round to output precision, saturate, zero on a bad order
   always_ff @(posedge clock) begin
      sum_type v;
      sum_type lim;
      lim = sum_type'(1) <<< FRAC_BITS;
      if (pipe_en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               v = round_shift(f_sum[r][c], FINAL_SHIFT);
               if (v > lim) v = lim;
               if (v < -lim) v = -lim;
               if (ctl_m2_ff[1].err) v = '0;
               fin_ff[r*3+c] <= v[OUT_BITS-1:0];
            end
         end
      end
   end

   // control along the matrix stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff     <= '0;
         ctl_m1_ff[0] <= '0;
         ctl_m1_ff[1] <= '0;
         ctl_r_ff     <= '0;
         ctl_m2_ff[0] <= '0;
         ctl_m2_ff[1] <= '0;
         ctl_f_ff     <= '0;
      end else if (pipe_en) begin
         ctl_b_ff.valid <= tag_ff[SC_LAT-1].valid;
         ctl_b_ff.err   <= order_bad(tag_ff[SC_LAT-1].order);
         ctl_m1_ff[0]   <= ctl_b_ff;
         ctl_m1_ff[1]   <= ctl_m1_ff[0];
         ctl_r_ff       <= ctl_m1_ff[1];
         ctl_m2_ff[0]   <= ctl_r_ff;
         ctl_m2_ff[1]   <= ctl_m2_ff[0];
         ctl_f_ff       <= ctl_m2_ff[1];
      end
   end

   always_comb begin
      for (int i = 0; i < NELEM; i++) fin_flat[i*OUT_BITS +: OUT_BITS] = fin_ff[i];
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take_out) begin
            skid_v_ff <= 1'b0;
         end
      end else if (ctl_f_ff.valid) begin
         if (out_v_ff && !rsp_tready) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (take_out) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take_out) begin
            out_ff     <= skid_ff;
            out_err_ff <= skid_err_ff;
         end
      end else if (ctl_f_ff.valid) begin
         if (out_v_ff && !rsp_tready) begin
            skid_ff     <= fin_flat;
            skid_err_ff <= ctl_f_ff.err;
         end else begin
            out_ff     <= fin_flat;
            out_err_ff <= ctl_f_ff.err;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_err_ff;
   assign rsp_tdata  = {6'd0, out_ff};

   // skid stage only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage holds a result while the output register is empty");

   // a stalled input side always traces back to a refused result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("request side stalled without output backpressure");

   // bad order codes give an all-zero matrix
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("order error with a nonzero matrix");

endmodule

`default_nettype wire

FILE: hw/rtl/e2dcm_sincos.sv
// pipelined sine and cosine of one binary angle, taylor series one term per two stages
// depends on e2dcm_pkg
`default_nettype none

module e2dcm_sincos
   import e2dcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output      trig_type              sin_out,
   output      trig_type              cos_out
);

   logic [REM_BITS+20:0] ph_ff, pl_ff;
   logic [1:0]           q0_ff, q1_ff;
   logic [X_BITS-1:0]    x1_ff;
   logic [X_BITS-1:0]    x_in;
   logic [63:0]          xx_in;

   logic [TERM_BITS-1:0]       st_ff [0:TERM_STEPS];
   logic [TERM_BITS-1:0]       ct_ff [0:TERM_STEPS];
   logic signed [ACC_BITS-1:0] ss_ff [0:TERM_STEPS];
   logic signed [ACC_BITS-1:0] cs_ff [0:TERM_STEPS];
   logic [TERM_BITS-1:0]       x2_ff [0:TERM_STEPS];
   logic [1:0]                 q_ff  [0:TERM_STEPS];

   logic [TERM_BITS-1:0]       sp_ff [0:TERM_STEPS-1];
   logic [TERM_BITS-1:0]       cp_ff [0:TERM_STEPS-1];
   logic signed [ACC_BITS-1:0] ssm_ff [0:TERM_STEPS-1];
   logic signed [ACC_BITS-1:0] csm_ff [0:TERM_STEPS-1];
   logic [TERM_BITS-1:0]       x2m_ff [0:TERM_STEPS-1];
   logic [1:0]                 qm_ff  [0:TERM_STEPS-1];

   trig_type sin_ff, cos_ff;
   logic signed [ACC_BITS-1:0] s_cl, c_cl;
   logic [57:0] xs_sum;

   localparam logic signed [ACC_BITS-1:0] ONE_ACC = ACC_BITS'(64'd1 << WORK_BITS);

   // angle scaling, r * pi in two partial products
   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= (REM_BITS+21)'(angle[REM_BITS-1:0]) * (REM_BITS+21)'(PI_HI);
         pl_ff <= (REM_BITS+21)'(angle[REM_BITS-1:0]) * (REM_BITS+21)'(PI_LO);
         q0_ff <= angle[ANGLE_BITS-1 -: 2];
      end
   end

   assign xs_sum = (58'(ph_ff) << PI_SPLIT) + 58'(pl_ff) + (58'd1 << (X_SHIFT - 1));
   assign x_in   = xs_sum[X_SHIFT +: X_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x_in;
         q1_ff <= q0_ff;
      end
   end

   assign xx_in = 64'(x1_ff) * 64'(x1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= TERM_BITS'(x1_ff);
         ct_ff[0] <= TERM_BITS'(64'd1 << WORK_BITS);
         ss_ff[0] <= ACC_BITS'(x1_ff);
         cs_ff[0] <= ONE_ACC;
         x2_ff[0] <= xx_in[WORK_BITS +: TERM_BITS];
         q_ff[0]  <= q1_ff;
      end
   end

   for (genvar k = 0; k < TERM_STEPS; k++) begin : g_step
      localparam int CD = cos_div(k);
      localparam int CL = $clog2(CD);
      localparam int CS = TERM_BITS + CL;
      localparam longint unsigned CM = ((64'd1 << CS) + 64'(CD) - 64'd1) / 64'(CD);

      logic [63:0] sprod, cprod;
      logic [71:0] cq;
      logic [TERM_BITS-1:0] sq;

      assign sprod = 64'(st_ff[k]) * 64'(x2_ff[k]);
      assign cprod = 64'(ct_ff[k]) * 64'(x2_ff[k]);
      assign cq    = 72'(cp_ff[k]) * 72'(CM);

      // term times x squared
      always_ff @(posedge clock) begin
         if (en) begin
            sp_ff[k]  <= sprod[WORK_BITS +: TERM_BITS];
            cp_ff[k]  <= cprod[WORK_BITS +: TERM_BITS];
            ssm_ff[k] <= ss_ff[k];
            csm_ff[k] <= cs_ff[k];
            x2m_ff[k] <= x2_ff[k];
            qm_ff[k]  <= q_ff[k];
         end
      end

      if (k < TERM_STEPS - 1) begin : g_sin
         localparam int SD = sin_div(k);
         localparam int SL = $clog2(SD);
         localparam int SS = TERM_BITS + SL;
         localparam longint unsigned SM = ((64'd1 << SS) + 64'(SD) - 64'd1) / 64'(SD);
         logic [71:0] sqw;
         assign sqw = 72'(sp_ff[k]) * 72'(SM);
         assign sq  = sqw[SS +: TERM_BITS];
      end else begin : g_sin_idle
         assign sq = '0;
      end

      // exact floor division by reciprocal, then alternate-sign accumulate
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= sq;
            ct_ff[k+1] <= cq[CS +: TERM_BITS];
            if (k % 2 == 0) begin
               ss_ff[k+1] <= ssm_ff[k] - ACC_BITS'(sq);
               cs_ff[k+1] <= csm_ff[k] - ACC_BITS'(cq[CS +: TERM_BITS]);
            end else begin
               ss_ff[k+1] <= ssm_ff[k] + ACC_BITS'(sq);
               cs_ff[k+1] <= csm_ff[k] + ACC_BITS'(cq[CS +: TERM_BITS]);
            end
            x2_ff[k+1] <= x2m_ff[k];
            q_ff[k+1]  <= qm_ff[k];
         end
      end
   end

   always_comb begin
      s_cl = ss_ff[TERM_STEPS];
      c_cl = cs_ff[TERM_STEPS];
      if (s_cl < 0) s_cl = '0;
      else if (s_cl > ONE_ACC) s_cl = ONE_ACC;
      if (c_cl < 0) c_cl = '0;
      else if (c_cl > ONE_ACC) c_cl = ONE_ACC;
   end

   // quadrant fold
   always_ff @(posedge clock) begin
      if (en) begin
         unique case (q_ff[TERM_STEPS])
            2'd0: begin sin_ff <= trig_type'(s_cl);  cos_ff <= trig_type'(c_cl);  end
            2'd1: begin sin_ff <= trig_type'(c_cl);  cos_ff <= -trig_type'(s_cl); end
            2'd2: begin sin_ff <= -trig_type'(s_cl); cos_ff <= -trig_type'(c_cl); end
            default: begin sin_ff <= -trig_type'(c_cl); cos_ff <= trig_type'(s_cl); end
         endcase
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/e2dcm_matmul.sv
// two-stage 3x3 matrix product: registered products, then registered row sums
// depends on e2dcm_pkg
`default_nettype none

module e2dcm_matmul
   import e2dcm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    en,
   input  wire mat_type lhs,
   input  wire mat_type rhs,
   output sum_mat_type prod_sum
);

   prod_type    prod_ff [3][3][3];
   sum_mat_type sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               for (int t = 0; t < 3; t++)
                  prod_ff[r][c][t] <= prod_type'(lhs[r][t]) * prod_type'(rhs[t][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               sum_ff[r][c] <= sum_type'(prod_ff[r][c][0]) + sum_type'(prod_ff[r][c][1]) +
                               sum_type'(prod_ff[r][c][2]);
      end
   end

   assign prod_sum = sum_ff;

endmodule

`default_nettype wire

FILE: dv/euler_angles_to_dcm_unit_tb.sv
// testbench for euler_angles_to_dcm_unit: directed and random angle triples
// checked against an in-bench fixed-point dcm predictor; needs e2dcm_pkg and the rtl
`default_nettype none

class dcm_scoreboard;
   typedef struct {
      logic [161:0] mat;
      logic         err;
   } dcm_result_type;

   dcm_result_type pending[$];
   int             errors;

   // sine and cosine of a binary angle in q30, taylor series as the block does
   static function void angle_trig(input logic [15:0] ang, output longint sn,
                                   output longint cs);
      logic [1:0]  quad;
      logic [63:0] x, x2, term, rem;
      longint      s, c;
      bit          neg;
      quad = ang[15:14];
      rem  = {50'd0, ang[13:0]};
      x    = (rem * 64'h3243F6A8886 + (64'd1 << 24)) >> 25;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      c    = longint'(1) << 30;
      neg  = 1;
      for (int n = 2; n <= 14; n += 2) begin
         term = ((term * x2) >> 30) / (n * (n + 1));
         s    = neg ? s - longint'(term) : s + longint'(term);
         neg  = !neg;
      end
      term = 64'd1 << 30;
      neg  = 1;
      for (int n = 1; n <= 15; n += 2) begin
         term = ((term * x2) >> 30) / (n * (n + 1));
         c    = neg ? c - longint'(term) : c + longint'(term);
         neg  = !neg;
      end
      if (s < 0) s = 0;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      if (c < 0) c = 0;
      if (c > (longint'(1) << 30)) c = longint'(1) << 30;
      case (quad)
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   static function longint round_away(input logic signed [127:0] v, input int sh);
      logic signed [127:0] mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (128'sd1 <<< (sh - 1))) >>> sh;
      return longint'((v < 0) ? -mag : mag);
   endfunction

   static function void single_axis(input int axis, input logic [15:0] ang,
                                    output longint m[3][3]);
      longint s, c;
      int     j, k;
      angle_trig(ang, s, c);
      j = (axis + 1) % 3;
      k = (axis + 2) % 3;
      for (int r = 0; r < 3; r++)
         for (int q = 0; q < 3; q++) m[r][q] = 0;
      m[axis][axis] = longint'(1) << 30;
      m[j][j] = c;
      m[k][k] = c;
      m[j][k] = s;
      m[k][j] = -s;
   endfunction

   static function void mat_product(input longint a[3][3], input longint b[3][3],
                                    input int sh, output longint o[3][3]);
      logic signed [127:0] acc;
      for (int r = 0; r < 3; r++)
         for (int q = 0; q < 3; q++) begin
            acc = 0;
            for (int t = 0; t < 3; t++) acc += 128'(a[r][t]) * 128'(b[t][q]);
            o[r][q] = round_away(acc, sh);
         end
   endfunction

   static function int axis_at(input logic [2:0] ord, input int pos);
      case (ord)
         e2dcm_pkg::ORDER_XYZ: return (pos == 0) ? 0 : (pos == 1) ? 1 : 2;
         e2dcm_pkg::ORDER_XZY: return (pos == 0) ? 0 : (pos == 1) ? 2 : 1;
         e2dcm_pkg::ORDER_YXZ: return (pos == 0) ? 1 : (pos == 1) ? 0 : 2;
         e2dcm_pkg::ORDER_YZX: return (pos == 0) ? 1 : (pos == 1) ? 2 : 0;
         e2dcm_pkg::ORDER_ZXY: return (pos == 0) ? 2 : (pos == 1) ? 0 : 1;
         default:              return (pos == 0) ? 2 : (pos == 1) ? 1 : 0;
      endcase
   endfunction

   function void note_request(input logic [47:0] angles, input logic [2:0] ord);
      dcm_result_type exp_res;
      longint         r1[3][3], r2[3][3], r3[3][3], tmp[3][3], res[3][3];
      longint         v;
      exp_res.mat = '0;
      exp_res.err = 1'b0;
      if (ord > e2dcm_pkg::ORDER_ZYX) begin
         exp_res.err = 1'b1;
      end else begin
         single_axis(axis_at(ord, 0), angles[15:0], r1);
         single_axis(axis_at(ord, 1), angles[31:16], r2);
         single_axis(axis_at(ord, 2), angles[47:32], r3);
         mat_product(r3, r2, 30, tmp);
         mat_product(tmp, r1, 44, res);
         for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++) begin
               v = res[r][q];
               if (v > 65536) v = 65536;
               if (v < -65536) v = -65536;
               exp_res.mat[(r * 3 + q) * 18 +: 18] = v[17:0];
            end
      end
      pending.push_back(exp_res);
   endfunction

   task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_result(input logic [167:0] data, input logic err);
      dcm_result_type exp_res;
      if (pending.size() == 0) begin
         report("unexpected result");
         return;
      end
      exp_res = pending.pop_front();
      for (int e = 0; e < 9; e++)
         if (data[e * 18 +: 18] !== exp_res.mat[e * 18 +: 18])
            report($sformatf("m%0d%0d got %h exp %h", e / 3, e % 3,
                             data[e * 18 +: 18], exp_res.mat[e * 18 +: 18]));
      if (err !== exp_res.err)
         report($sformatf("order_error got %b exp %b", err, exp_res.err));
   endtask
endclass

module euler_angles_to_dcm_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [47:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   dcm_scoreboard dcm_board = new();

   // idle percentages for the sender and the receiver, changed per phase
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   // receiver hold-off length in cycles, zero when not holding off
   int  hold_off = 0;
   longint cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   euler_angles_to_dcm_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // watchdog: far beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: check every accepted result, then choose next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) dcm_board.check_result(rsp_tdata, rsp_tuser);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one request and hold it until accepted, with random idle first
   task automatic send_request(input logic [15:0] a1, input logic [15:0] a2,
                               input logic [15:0] a3, input logic [2:0] ord);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {a3, a2, a1};
      req_tuser  <= ord;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      dcm_board.note_request({a3, a2, a1}, ord);
   endtask

   // random angle: mostly full range, some near quadrant edges
   function automatic logic [15:0] pick_angle();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(3) == 0) a = {a[15:14], 14'($urandom_range(3))} - 16'd1;
      return a;
   endfunction

   task automatic run_random(input int count);
      logic [2:0] ord;
      for (int i = 0; i < count; i++) begin
         ord = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                        : 3'($urandom_range(5));
         send_request(pick_angle(), pick_angle(), pick_angle(), ord);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [15:0] edge_angles[6];
      edge_angles = '{16'h0000, 16'h3FFF, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every order code incl. the invalid ones, angle extremes
      for (int o = 0; o < 8; o++)
         send_request(edge_angles[o % 6], edge_angles[(o + 2) % 6],
                      edge_angles[(o + 4) % 6], 3'(o));
      for (int i = 0; i < 6; i++)
         send_request(edge_angles[i], edge_angles[5 - i], 16'h2000, e2dcm_pkg::ORDER_ZYX);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
      send_request(16'h5555, 16'hAAAA, 16'h1234, e2dcm_pkg::ORDER_XYZ);

      // no idling
      run_random(150);
      // long receiver hold-off while requests keep coming
      hold_off = 200;
      run_random(100);
      // sender idle
      send_idle_pct = 57;
      run_random(160);
      // receiver stalling
      send_idle_pct = 0;
      recv_stall_pct = 57;
      run_random(160);
      // both
      send_idle_pct = 16;
      recv_stall_pct = 16;
      run_random(160);

      while (dcm_board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (dcm_board.errors == 0 && dcm_board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

`default_nettype wire
